// ----- hw/rtl/keyed_record_hash_aggregator_unit_assert.svh -----
// Assertion helpers for the RTL files; krha_back.sv includes them.
`ifndef KEYED_RECORD_HASH_AGGREGATOR_UNIT_ASSERT_SVH
`define KEYED_RECORD_HASH_AGGREGATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define KRHA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define KRHA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`else

`define KRHA_ASSERT(lbl, clk, rst_n, prop)

`define KRHA_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- hw/rtl/krha_pkg.sv -----
package krha_pkg;

    // BIN_COUNT must be a power of two: the bin is the low hash bits.
    localparam int BIN_COUNT      = 16384;
    localparam int BIN_W          = $clog2(BIN_COUNT);
    localparam int PROBE_W        = BIN_W + 1;
    localparam int MAX_KEY        = 100;
    localparam int KEY_POS_W      = 7;
    localparam int LEN_W          = 7;
    localparam int FOLD_BYTES     = 16;
    localparam int LINE_ADDR_W    = KEY_POS_W + 1;
    localparam int LINE_MEM_DEPTH = 1 << LINE_ADDR_W;
    localparam int KEY_ADDR_W     = BIN_W + KEY_POS_W;
    localparam int KEY_MEM_DEPTH  = 1 << KEY_ADDR_W;
    localparam int MUL_W          = 19;

    localparam logic [MUL_W-1:0] HASH_MUL  = 19'd276187;
    localparam logic signed [11:0] MIN_INIT = 12'sd1024;
    localparam logic signed [11:0] MAX_INIT = -12'sd1024;

    typedef enum logic [2:0] {
        ST_STORED   = 3'd0,
        ST_READ     = 3'd1,
        ST_TOO_LONG = 3'd2,
        ST_FULL     = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CMD_READ,
        CMD_LINE,
        CMD_TOO_LONG,
        CMD_EMPTY
    } t_cmd;

    typedef struct packed {
        t_cmd                  kind;
        logic                  bank;
        logic [LEN_W-1:0]      key_len;
        logic signed [10:0]    line_value;
        logic [63:0]           fold;
        logic [31:0]           tail;
        logic [31:0]           power;
        logic [BIN_W-1:0]      read_bin;
        logic [KEY_POS_W-1:0]  read_pos;
    } t_cmd_entry;

    typedef struct packed {
        logic                  used;
        logic [LEN_W-1:0]      key_len;
        logic [31:0]           count;
        logic signed [63:0]    total;
        logic signed [11:0]    minimum;
        logic signed [11:0]    maximum;
    } t_bin_stats;

    typedef struct packed {
        t_status               status;
        logic [BIN_W-1:0]      bin;
        logic                  occupied;
        logic [LEN_W-1:0]      key_length;
        logic [7:0]            key_byte;
        logic signed [10:0]    line_value;
        logic [31:0]           count;
        logic signed [63:0]    total;
        logic signed [11:0]    minimum;
        logic signed [11:0]    maximum;
    } t_result;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_HASH_LO,
        BK_HASH_HI,
        BK_HASH_TAIL,
        BK_PROBE_RD,
        BK_PROBE_CHK,
        BK_CMP_RD,
        BK_CMP_CHK,
        BK_CPY_RD,
        BK_CPY_WR,
        BK_UPDATE,
        BK_READ_WAIT,
        BK_EMIT
    } t_back_st;

    localparam t_bin_stats BIN_CLEAR = '{
        used: 1'b0, key_len: '0, count: '0, total: '0,
        minimum: MIN_INIT, maximum: MAX_INIT
    };

endpackage

// ----- hw/rtl/krha_front.sv -----
module krha_front import krha_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_req_type,
    input  logic [7:0]             i_data_byte,
    input  logic [BIN_W-1:0]       i_read_bin,
    input  logic [KEY_POS_W-1:0]   i_read_key_pos,
    input  logic [LINE_ADDR_W-1:0] i_lk_raddr,
    output logic [7:0]             o_lk_rdata,
    output logic                   o_push,
    output t_cmd_entry             o_entry
);

    localparam logic [7:0] CHR_NL    = 8'h0A;
    localparam logic [7:0] CHR_SEMI  = 8'h3B;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_POINT = 8'h2E;

    logic [LEN_W-1:0] r_len, n_len;
    logic             r_in_value, n_in_value;
    logic             r_neg, n_neg;
    logic [9:0]       r_tenths, n_tenths;
    logic [63:0]      r_fold, n_fold;
    logic [31:0]      r_tail, n_tail;
    logic [31:0]      r_power, n_power;
    logic             r_bank, n_bank;
    logic             key_wr;
    logic [10:0]      mag;
    logic [7:0]       r_line_mem [0:LINE_MEM_DEPTH-1];
    logic [7:0]       r_lk_rdata;

    assign mag        = {1'b0, r_tenths};
    assign o_lk_rdata = r_lk_rdata;

    always_comb begin
        n_len      = r_len;
        n_in_value = r_in_value;
        n_neg      = r_neg;
        n_tenths   = r_tenths;
        n_fold     = r_fold;
        n_tail     = r_tail;
        n_power    = r_power;
        n_bank     = r_bank;
        key_wr     = 1'b0;
        o_push     = 1'b0;
        o_entry            = '0;
        o_entry.kind       = CMD_READ;
        o_entry.bank       = r_bank;
        o_entry.key_len    = r_len;
        o_entry.line_value = r_neg ? $signed(~mag + 11'd1) : $signed(mag);
        o_entry.fold       = r_fold;
        o_entry.tail       = r_tail;
        o_entry.power      = r_power;
        o_entry.read_bin   = i_read_bin;
        o_entry.read_pos   = i_read_key_pos;
        if (i_accept) begin
            if (i_req_type) begin
                o_push = 1'b1;
            end else if (i_data_byte == CHR_NL) begin
                if (r_in_value) begin
                    o_push = 1'b1;
                    if (r_len == '0) begin
                        o_entry.kind = CMD_EMPTY;
                    end else if (r_len > LEN_W'(MAX_KEY)) begin
                        o_entry.kind = CMD_TOO_LONG;
                    end else begin
                        o_entry.kind = CMD_LINE;
                        // The key buffer now belongs to the back end until it pops the line.
                        n_bank = ~r_bank;
                    end
                end
                n_len      = '0;
                n_in_value = 1'b0;
                n_neg      = 1'b0;
                n_tenths   = '0;
                n_fold     = '0;
                n_tail     = '0;
                n_power    = 32'd1;
            end else if (!r_in_value) begin
                if (i_data_byte == CHR_SEMI) begin
                    n_in_value = 1'b1;
                end else begin
                    if (r_len < LEN_W'(FOLD_BYTES)) begin
                        for (int l = 0; l < 8; l++) begin
                            if (r_len[2:0] == 3'(l)) begin
                                n_fold[8*l +: 8] = r_fold[8*l +: 8] + i_data_byte;
                            end
                        end
                    end else begin
                        // Tail hash kept as fold * power + tail, resolved at line end.
                        n_tail  = 32'(r_tail * 32'(HASH_MUL)) + 32'(i_data_byte);
                        n_power = 32'(r_power * 32'(HASH_MUL));
                    end
                    key_wr = (r_len < LEN_W'(MAX_KEY));
                    if (r_len <= LEN_W'(MAX_KEY)) begin
                        n_len = r_len + LEN_W'(1);
                    end
                end
            end else if (i_data_byte == CHR_MINUS) begin
                n_neg = 1'b1;
            end else if (i_data_byte != CHR_POINT) begin
                n_tenths = 10'(r_tenths * 10'd10 + 10'(i_data_byte[3:0]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len      <= '0;
            r_in_value <= 1'b0;
            r_neg      <= 1'b0;
            r_tenths   <= '0;
            r_fold     <= '0;
            r_tail     <= '0;
            r_power    <= 32'd1;
            r_bank     <= 1'b0;
        end else begin
            r_len      <= n_len;
            r_in_value <= n_in_value;
            r_neg      <= n_neg;
            r_tenths   <= n_tenths;
            r_fold     <= n_fold;
            r_tail     <= n_tail;
            r_power    <= n_power;
            r_bank     <= n_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (key_wr) begin
            r_line_mem[{r_bank, r_len[KEY_POS_W-1:0]}] <= i_data_byte;
        end
        r_lk_rdata <= r_line_mem[i_lk_raddr];
    end

endmodule

// ----- hw/rtl/krha_fifo.sv -----
module krha_fifo import krha_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_cmd_entry i_entry,
    input  logic       i_pop,
    output logic       o_full,
    output logic       o_valid,
    output t_cmd_entry o_head
);

    t_cmd_entry r_mem [0:1];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(i_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

// ----- hw/rtl/krha_back.sv -----
`include "keyed_record_hash_aggregator_unit_assert.svh"

module krha_back import krha_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  t_cmd_entry             i_q_head,
    output logic                   o_q_pop,
    output logic [LINE_ADDR_W-1:0] o_lk_raddr,
    input  logic [7:0]             i_lk_rdata,
    output logic                   o_clearing,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_result                o_out
);

    t_back_st             r_state, n_state;
    logic [BIN_W-1:0]     r_clr_idx, n_clr_idx;
    logic [BIN_W-1:0]     r_bin, n_bin;
    logic [PROBE_W-1:0]   r_probes, n_probes;
    logic [KEY_POS_W-1:0] r_idx, n_idx;
    logic [50:0]          r_plo, n_plo;
    logic [31:0]          r_hf, n_hf;
    t_bin_stats           r_stats, n_stats;
    t_result              r_res, n_res;
    logic                 r_out_valid, n_out_valid;
    t_result              r_out, n_out;

    t_bin_stats           r_st_mem [0:BIN_COUNT-1];
    logic [7:0]           r_key_mem [0:KEY_MEM_DEPTH-1];
    t_bin_stats           r_st_rdata;
    logic [7:0]           r_km_rdata;

    logic [BIN_W-1:0]      st_raddr, st_waddr;
    logic                  st_we;
    t_bin_stats            st_wdata;
    logic [KEY_ADDR_W-1:0] km_raddr;
    logic                  km_we;

    logic                  out_free, last_probe, last_idx, len_eq, byte_eq;
    logic [31:0]           hi_m, hash;
    logic [19:0]           hf_upper;
    logic signed [63:0]    value_ext;
    logic signed [11:0]    value12;

    assign out_free    = !r_out_valid || i_out_ready;
    assign last_probe  = (r_probes == PROBE_W'(BIN_COUNT - 1));
    assign last_idx    = (r_idx == KEY_POS_W'(i_q_head.key_len - LEN_W'(1)));
    assign len_eq      = (r_st_rdata.key_len == i_q_head.key_len);
    assign byte_eq     = (r_km_rdata == i_lk_rdata);
    assign hi_m        = 32'(i_q_head.fold[63:32] * 32'(HASH_MUL));
    // Bits 51..20 of the 64-bit fold product; only the upper 20 need the high half.
    assign hf_upper    = 20'({1'b0, r_plo[50:32]} + hi_m[19:0]);
    assign hash        = (i_q_head.key_len > LEN_W'(FOLD_BYTES)) ?
                         32'(r_hf * i_q_head.power) + i_q_head.tail : r_hf;
    assign value_ext   = 64'(i_q_head.line_value);
    assign value12     = 12'(i_q_head.line_value);
    assign o_clearing  = (r_state == BK_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_CLEAR: begin
                if (r_clr_idx == BIN_W'(BIN_COUNT - 1)) n_state = BK_IDLE;
            end
            BK_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_head.kind)
                        CMD_READ:     n_state = BK_READ_WAIT;
                        CMD_LINE:     n_state = BK_HASH_LO;
                        CMD_TOO_LONG: n_state = BK_EMIT;
                        CMD_EMPTY:    n_state = BK_EMIT;
                    endcase
                end
            end
            BK_HASH_LO:   n_state = BK_HASH_HI;
            BK_HASH_HI:   n_state = BK_HASH_TAIL;
            BK_HASH_TAIL: n_state = BK_PROBE_RD;
            BK_PROBE_RD:  n_state = BK_PROBE_CHK;
            BK_PROBE_CHK: begin
                priority if (!r_st_rdata.used) n_state = BK_CPY_RD;
                else if (len_eq)               n_state = BK_CMP_RD;
                else if (last_probe)           n_state = BK_EMIT;
                else                           n_state = BK_PROBE_RD;
            end
            BK_CMP_RD:    n_state = BK_CMP_CHK;
            BK_CMP_CHK: begin
                priority if (byte_eq) n_state = last_idx ? BK_UPDATE : BK_CMP_RD;
                else if (last_probe)  n_state = BK_EMIT;
                else                  n_state = BK_PROBE_RD;
            end
            BK_CPY_RD:    n_state = BK_CPY_WR;
            BK_CPY_WR:    n_state = last_idx ? BK_UPDATE : BK_CPY_RD;
            BK_UPDATE:    n_state = BK_EMIT;
            BK_READ_WAIT: n_state = BK_EMIT;
            BK_EMIT: begin
                if (out_free) n_state = BK_IDLE;
            end
            default:      n_state = BK_CLEAR;
        endcase
    end

    always_comb begin
        n_clr_idx   = r_clr_idx;
        n_bin       = r_bin;
        n_probes    = r_probes;
        n_idx       = r_idx;
        n_plo       = r_plo;
        n_hf        = r_hf;
        n_stats     = r_stats;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        st_raddr    = r_bin;
        st_waddr    = r_bin;
        st_we       = 1'b0;
        st_wdata    = r_stats;
        km_raddr    = {r_bin, r_idx};
        km_we       = 1'b0;
        o_lk_raddr  = {i_q_head.bank, r_idx};
        o_q_pop     = 1'b0;
        unique case (r_state)
            BK_CLEAR: begin
                st_we     = 1'b1;
                st_waddr  = r_clr_idx;
                st_wdata  = BIN_CLEAR;
                n_clr_idx = r_clr_idx + BIN_W'(1);
            end
            BK_IDLE: begin
                st_raddr = i_q_head.read_bin;
                km_raddr = {i_q_head.read_bin, i_q_head.read_pos};
                n_res    = '0;
                n_res.status = (i_q_head.kind == CMD_EMPTY) ? ST_EMPTY : ST_TOO_LONG;
            end
            BK_HASH_LO: begin
                n_plo = 51'(51'(i_q_head.fold[31:0]) * 51'(HASH_MUL));
            end
            BK_HASH_HI: begin
                n_hf = {hf_upper, r_plo[31:20]};
            end
            BK_HASH_TAIL: begin
                n_bin    = hash[BIN_W-1:0];
                n_probes = '0;
            end
            BK_PROBE_RD: begin
            end
            BK_PROBE_CHK: begin
                n_stats = r_st_rdata;
                n_idx   = '0;
                if (!r_st_rdata.used) begin
                    n_stats.used    = 1'b1;
                    n_stats.key_len = i_q_head.key_len;
                end else if (!len_eq) begin
                    n_bin    = r_bin + BIN_W'(1);
                    n_probes = r_probes + PROBE_W'(1);
                    n_res        = '0;
                    n_res.status = ST_FULL;
                end
            end
            BK_CMP_RD: begin
            end
            BK_CMP_CHK: begin
                if (byte_eq) begin
                    n_idx = r_idx + KEY_POS_W'(1);
                end else begin
                    n_bin    = r_bin + BIN_W'(1);
                    n_probes = r_probes + PROBE_W'(1);
                    n_res        = '0;
                    n_res.status = ST_FULL;
                end
            end
            BK_CPY_RD: begin
            end
            BK_CPY_WR: begin
                km_we = 1'b1;
                n_idx = r_idx + KEY_POS_W'(1);
            end
            BK_UPDATE: begin
                st_we    = 1'b1;
                st_wdata = r_stats;
                if (r_stats.count != 32'hFFFF_FFFF) st_wdata.count = r_stats.count + 32'd1;
                st_wdata.total = r_stats.total + value_ext;
                if (value12 < r_stats.minimum) st_wdata.minimum = value12;
                if (value12 > r_stats.maximum) st_wdata.maximum = value12;
                n_res.status     = ST_STORED;
                n_res.bin        = r_bin;
                n_res.occupied   = 1'b1;
                n_res.key_length = r_stats.key_len;
                n_res.key_byte   = '0;
                n_res.line_value = i_q_head.line_value;
                n_res.count      = st_wdata.count;
                n_res.total      = st_wdata.total;
                n_res.minimum    = st_wdata.minimum;
                n_res.maximum    = st_wdata.maximum;
            end
            BK_READ_WAIT: begin
                n_res.status     = ST_READ;
                n_res.bin        = i_q_head.read_bin;
                n_res.occupied   = r_st_rdata.used;
                n_res.key_length = r_st_rdata.key_len;
                n_res.key_byte   = (r_st_rdata.used &&
                                    LEN_W'(i_q_head.read_pos) < r_st_rdata.key_len) ?
                                   r_km_rdata : 8'd0;
                n_res.line_value = '0;
                n_res.count      = r_st_rdata.count;
                n_res.total      = r_st_rdata.total;
                n_res.minimum    = r_st_rdata.minimum;
                n_res.maximum    = r_st_rdata.maximum;
            end
            BK_EMIT: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    o_q_pop     = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr_idx   <= '0;
            r_probes    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_probes    <= n_probes;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin   <= n_bin;
        r_idx   <= n_idx;
        r_plo   <= n_plo;
        r_hf    <= n_hf;
        r_stats <= n_stats;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_st_mem[st_waddr] <= st_wdata;
        end
        r_st_rdata <= r_st_mem[st_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (km_we) begin
            r_key_mem[{r_bin, r_idx}] <= i_lk_rdata;
        end
        r_km_rdata <= r_key_mem[km_raddr];
    end

    `KRHA_ASSERT(a_clear_holds_queue, i_clk, i_rst_n, (r_state == BK_CLEAR) |-> !i_q_valid)
    `KRHA_ASSERT(a_emit_loads_out, i_clk, i_rst_n, (r_state == BK_EMIT && out_free) |=> (r_out_valid && r_state == BK_IDLE))
    `KRHA_ASSERT(a_cmp_same_len, i_clk, i_rst_n, (r_state == BK_CMP_CHK) |-> (r_stats.key_len == i_q_head.key_len))
    `KRHA_ASSERT(a_probe_bound, i_clk, i_rst_n, r_probes <= PROBE_W'(BIN_COUNT))

endmodule

// ----- hw/rtl/keyed_record_hash_aggregator_unit.sv -----
// Parses a byte stream of "key;value\n" lines and keeps count, sum, minimum
// and maximum per key in a 16384-bin hash table with linear probing; read
// requests return one bin and one byte of its key. After reset the table is
// cleared one bin per cycle, and s_axis_tready stays low until it is done.
// The front end takes one stream byte per cycle as long as its two-entry
// queue to the table engine has room. At a line end the table engine picks up
// the command, hashes the key, reads and checks each probed bin, compares each
// key byte of a bin with a key of equal length, copies each byte when a new key
// is stored, updates the bin and hands the result to the output register; a
// read fetches its bin and key byte, and an empty or overlong key goes straight
// to the output. These table memory accesses set the rate.
module keyed_record_hash_aggregator_unit import krha_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [7:0] data_byte, [21:8] read_bin, [28:22] read_key_pos
    input  logic [31:0]  s_axis_tdata,
    // [0] req_type
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [13:0] bin, [14] occupied, [21:15] key_length, [29:22] key_byte,
    // [40:30] line_value, [72:41] count, [136:73] total, [148:137] minimum,
    // [160:149] maximum
    output logic [167:0] m_axis_tdata,
    // [2:0] status
    output logic [2:0]   m_axis_tuser
);

    logic                   accept, push, pop, full, q_valid, clearing;
    t_cmd_entry             entry, head;
    logic [LINE_ADDR_W-1:0] lk_raddr;
    logic [7:0]             lk_rdata;
    t_result                res;

    assign s_axis_tready = !full && !clearing;
    assign accept        = s_axis_tvalid && s_axis_tready;

    krha_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_req_type     (s_axis_tuser),
        .i_data_byte    (s_axis_tdata[7:0]),
        .i_read_bin     (s_axis_tdata[21:8]),
        .i_read_key_pos (s_axis_tdata[28:22]),
        .i_lk_raddr     (lk_raddr),
        .o_lk_rdata     (lk_rdata),
        .o_push         (push),
        .o_entry        (entry)
    );

    krha_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_head  (head)
    );

    krha_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_head    (head),
        .o_q_pop     (pop),
        .o_lk_raddr  (lk_raddr),
        .i_lk_rdata  (lk_rdata),
        .o_clearing  (clearing),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (res)
    );

    assign m_axis_tuser = res.status;
    assign m_axis_tdata = {7'd0, res.maximum, res.minimum, res.total, res.count,
                           res.line_value, res.key_byte, res.key_length,
                           res.occupied, res.bin};

endmodule

// ----- verif/keyed_record_hash_aggregator_unit_test.sv -----
module keyed_record_hash_aggregator_unit_test;
    import krha_pkg::*;

    localparam int LIMIT_CYCLES = 800000;
    localparam int ITEM_TARGET  = 1550;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [167:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;

    keyed_record_hash_aggregator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Shadow copy of the line parser and of the bin table.
    logic [7:0]  cur_key [MAX_KEY];
    int          cur_len;
    bit          cur_in_value;
    bit          cur_negative;
    logic [9:0]  cur_tenths;
    logic [63:0] cur_fold;
    logic [31:0] cur_tail_hash;

    bit          tbl_used  [BIN_COUNT];
    int          tbl_len   [BIN_COUNT];
    logic [7:0]  tbl_key   [BIN_COUNT][MAX_KEY];
    logic [31:0] tbl_count [BIN_COUNT];
    logic [63:0] tbl_sum   [BIN_COUNT];
    int          tbl_min   [BIN_COUNT];
    int          tbl_max   [BIN_COUNT];

    t_result     pending_results[$];
    int          filled_bins[$];
    int          errors;
    int          cycles;
    bit          calm;
    int          items_sent;

    typedef struct {
        bit      rd;
        string   txt;
        int      rbin;
        int      rpos;
        bit      has_want;
        t_status want;
    } t_row;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_result make_result(t_status st, int b, bit occ, int klen, int kb,
                                            int lval, logic [31:0] cnt, logic [63:0] sum,
                                            int mn, int mx);
        t_result r;
        r.status     = st;
        r.bin        = b[BIN_W-1:0];
        r.occupied   = occ;
        r.key_length = klen[LEN_W-1:0];
        r.key_byte   = kb[7:0];
        r.line_value = lval[10:0];
        r.count      = cnt;
        r.total      = sum;
        r.minimum    = mn[11:0];
        r.maximum    = mx[11:0];
        return r;
    endfunction

    function automatic logic [31:0] folded_hash();
        logic [63:0] p;
        p = cur_fold * 64'd276187;
        return p[51:20];
    endfunction

    function automatic void clear_line();
        cur_len       = 0;
        cur_in_value  = 0;
        cur_negative  = 0;
        cur_tenths    = '0;
        cur_fold      = '0;
        cur_tail_hash = '0;
    endfunction

    function automatic bit same_key(int b);
        if (!tbl_used[b] || tbl_len[b] != cur_len)
            return 0;
        for (int i = 0; i < cur_len; i++)
            if (tbl_key[b][i] !== cur_key[i])
                return 0;
        return 1;
    endfunction

    function automatic t_result close_line();
        int          v;
        int          b;
        bit          found;
        logic [31:0] h;
        v = cur_negative ? -int'(cur_tenths) : int'(cur_tenths);
        if (cur_len == 0)
            return make_result(ST_EMPTY, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        if (cur_len > MAX_KEY)
            return make_result(ST_TOO_LONG, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        h = (cur_len <= FOLD_BYTES) ? folded_hash() : cur_tail_hash;
        b = int'(h % BIN_COUNT);
        found = 0;
        for (int i = 0; i < BIN_COUNT; i++) begin
            if (!tbl_used[b] || same_key(b)) begin
                found = 1;
                break;
            end
            b = (b + 1) % BIN_COUNT;
        end
        if (!found)
            return make_result(ST_FULL, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        if (!tbl_used[b]) begin
            tbl_used[b] = 1;
            tbl_len[b]  = cur_len;
            for (int i = 0; i < cur_len; i++)
                tbl_key[b][i] = cur_key[i];
            filled_bins.push_back(b);
        end
        if (tbl_count[b] != 32'hFFFF_FFFF)
            tbl_count[b]++;
        tbl_sum[b] = tbl_sum[b] + 64'(signed'(v));
        if (v < tbl_min[b])
            tbl_min[b] = v;
        if (v > tbl_max[b])
            tbl_max[b] = v;
        return make_result(ST_STORED, b, 1, tbl_len[b], 0, v, tbl_count[b], tbl_sum[b],
                           tbl_min[b], tbl_max[b]);
    endfunction

    // Advances the shadow state by one item; returns 1 when a result is due.
    function automatic bit predict_item(bit rd, logic [7:0] c, logic [13:0] rb,
                                        logic [6:0] rp, output t_result r);
        int kb;
        int lane;
        r = '0;
        if (rd) begin
            kb = 0;
            if (tbl_used[rb] && rp < tbl_len[rb] && rp < MAX_KEY)
                kb = tbl_key[rb][rp];
            r = make_result(ST_READ, rb, tbl_used[rb], tbl_len[rb], kb, 0, tbl_count[rb],
                            tbl_sum[rb], tbl_min[rb], tbl_max[rb]);
            return 1;
        end
        if (c == 8'h0A) begin
            if (cur_in_value) begin
                r = close_line();
                clear_line();
                return 1;
            end
            clear_line();
            return 0;
        end
        if (!cur_in_value) begin
            if (c == 8'h3B) begin
                cur_in_value = 1;
            end else begin
                if (cur_len < FOLD_BYTES) begin
                    lane = cur_len % 8;
                    cur_fold[8*lane +: 8] = cur_fold[8*lane +: 8] + c;
                end else begin
                    if (cur_len == FOLD_BYTES)
                        cur_tail_hash = folded_hash();
                    cur_tail_hash = cur_tail_hash * 32'd276187 + c;
                end
                if (cur_len < MAX_KEY)
                    cur_key[cur_len] = c;
                if (cur_len <= MAX_KEY)
                    cur_len++;
            end
            return 0;
        end
        if (c == 8'h2D)
            cur_negative = 1;
        else if (c != 8'h2E)
            cur_tenths = 10'(cur_tenths * 10 + c[3:0]);
        return 0;
    endfunction

    // Returns the status the item produced, or -1 when no result was due.
    task automatic send_item(bit rd, logic [7:0] c, logic [13:0] rb, logic [6:0] rp,
                             output int got_status);
        t_result r;
        while (!calm && $urandom_range(99) < 22) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rd;
        s_axis_tdata  <= {3'b000, rp, rb, c};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        items_sent++;
        got_status = -1;
        if (predict_item(rd, c, rb, rp, r)) begin
            pending_results.push_back(r);
            got_status = int'(r.status);
        end
    endtask

    task automatic send_text(string s, output int got_status);
        int st;
        got_status = -1;
        for (int i = 0; i < s.len(); i++) begin
            send_item(0, s[i], 14'($urandom), 7'($urandom), st);
            if (st >= 0)
                got_status = st;
        end
    endtask

    always @(negedge i_clk)
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 22);

    always @(posedge i_clk) begin
        t_result e;
        t_result a;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            a.status     = t_status'(m_axis_tuser);
            a.bin        = m_axis_tdata[13:0];
            a.occupied   = m_axis_tdata[14];
            a.key_length = m_axis_tdata[21:15];
            a.key_byte   = m_axis_tdata[29:22];
            a.line_value = m_axis_tdata[40:30];
            a.count      = m_axis_tdata[72:41];
            a.total      = m_axis_tdata[136:73];
            a.minimum    = m_axis_tdata[148:137];
            a.maximum    = m_axis_tdata[160:149];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item status=%0d bin=%0d", $time, a.status, a.bin);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (e.status !== a.status || e.bin !== a.bin || e.occupied !== a.occupied ||
                    e.key_length !== a.key_length || e.key_byte !== a.key_byte ||
                    e.line_value !== a.line_value || e.count !== a.count ||
                    e.total !== a.total || e.minimum !== a.minimum ||
                    e.maximum !== a.maximum) begin
                    $display("%0t: mismatch expected %p", $time, e);
                    $display("%0t:          actual   %p", $time, a);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("keyed_record_hash_aggregator_unit_test: FAIL");
            $finish;
        end
    end

    function automatic string random_key(int n);
        string s;
        byte   c;
        s = "";
        for (int i = 0; i < n; i++) begin
            // A zero byte cannot live in a string, so it is never picked.
            do
                c = byte'($urandom_range(255));
            while (c == 8'h0A || c == 8'h3B || c == 8'h00);
            s = {s, string'(c)};
        end
        return s;
    endfunction

    function automatic string random_value();
        string s;
        s = ($urandom_range(99) < 35) ? "-" : "";
        if ($urandom_range(99) < 5) begin
            repeat ($urandom_range(3, 6))
                s = {s, string'(byte'(8'h30 + $urandom_range(9)))};
            return {s, "\n"};
        end
        repeat ($urandom_range(1, 2))
            s = {s, string'(byte'(8'h30 + $urandom_range(9)))};
        return {s, ".", string'(byte'(8'h30 + $urandom_range(9))), "\n"};
    endfunction

    initial begin
        t_row  rows[$];
        string keys[$];
        string long_key;
        string k;
        int    st;
        int    pick;
        bit    held;
        int    lens[12] = '{1, 2, 7, 8, 9, 15, 16, 17, 30, 64, 99, 100};

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        errors        = 0;
        cycles        = 0;
        calm          = 0;
        items_sent    = 0;
        held          = 0;
        clear_line();
        for (int i = 0; i < MAX_KEY; i++)
            cur_key[i] = '0;
        for (int b = 0; b < BIN_COUNT; b++) begin
            tbl_used[b]  = 0;
            tbl_len[b]   = 0;
            tbl_count[b] = '0;
            tbl_sum[b]   = '0;
            tbl_min[b]   = 1024;
            tbl_max[b]   = -1024;
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        long_key = random_key(MAX_KEY);
        rows = '{
            '{1, "", 0, 0, 1, ST_READ},
            '{1, "", BIN_COUNT - 1, 127, 1, ST_READ},
            '{0, "A;-99.9\n", 0, 0, 1, ST_STORED},
            '{0, "A;99.9\n", 0, 0, 1, ST_STORED},
            '{0, ";1.0\n", 0, 0, 1, ST_EMPTY},
            '{0, {long_key, "x;1.0\n"}, 0, 0, 1, ST_TOO_LONG},
            '{0, {long_key, ";-0.5\n"}, 0, 0, 1, ST_STORED},
            '{0, "noline\n", 0, 0, 0, ST_READ},
            '{0, "\n", 0, 0, 0, ST_READ},
            '{0, "k;1;2\n", 0, 0, 1, ST_STORED},
            '{0, "k;123.4\n", 0, 0, 1, ST_STORED},
            '{0, "k;1-2.3\n", 0, 0, 1, ST_STORED},
            '{0, "\377\200\001;0.0\n", 0, 0, 1, ST_STORED},
            '{0, "0123456789abcdefg;5.5\n", 0, 0, 1, ST_STORED},
            '{0, "0123456789abcdef;5.5\n", 0, 0, 1, ST_STORED}
        };
        foreach (rows[i]) begin
            if (rows[i].rd)
                send_item(1, 8'($urandom), 14'(rows[i].rbin), 7'(rows[i].rpos), st);
            else
                send_text(rows[i].txt, st);
            if (rows[i].has_want && st != int'(rows[i].want)) begin
                $display("%0t: directed row %0d expected status %0d, actual %0d",
                         $time, i, rows[i].want, st);
                errors++;
            end
        end

        for (int i = 0; i < 24; i++)
            keys.push_back(random_key(i < 12 ? lens[i] : $urandom_range(1, 12)));
        keys.push_back(long_key);

        while (items_sent < ITEM_TARGET) begin
            calm = (items_sent > 400 && items_sent < 650);
            if (!held && items_sent > 900) begin
                // Hold the stream until the table has answered every pending item.
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge i_clk);
                held = 1;
            end
            pick = $urandom_range(99);
            if (pick < 15) begin
                if (filled_bins.size() != 0 && $urandom_range(1))
                    send_item(1, 8'($urandom),
                              14'(filled_bins[$urandom_range(filled_bins.size() - 1)]),
                              7'($urandom_range(127)), st);
                else
                    send_item(1, 8'($urandom), 14'($urandom), 7'($urandom), st);
            end else if (pick < 22) begin
                send_item(0, 8'($urandom), 14'($urandom), 7'($urandom), st);
            end else if (pick < 28) begin
                send_text({random_key($urandom_range(0, 5)), "\n"}, st);
            end else begin
                k = ($urandom_range(9) < 8) ? keys[$urandom_range(keys.size() - 1)]
                                            : random_key($urandom_range(1, 20));
                if (k.len() > 40 && $urandom_range(3) != 0)
                    k = keys[$urandom_range(11)];
                send_text({k, ";", random_value()}, st);
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        if (errors == 0)
            $display("keyed_record_hash_aggregator_unit_test: PASS");
        else
            $display("keyed_record_hash_aggregator_unit_test: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/krha_pkg.sv
hw/rtl/krha_front.sv
hw/rtl/krha_fifo.sv
hw/rtl/krha_back.sv
hw/rtl/keyed_record_hash_aggregator_unit.sv
verif/keyed_record_hash_aggregator_unit_test.sv
